FILE: src/usu_pkg.sv
// Shared types for the UTF-8 substring selector.
// Holds the byte-group entry passed from the front end through the queue
// to the emitter. No dependencies.
package usu_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int GROUP_BYTES = 4;

  typedef struct packed {
    logic [GROUP_BYTES-1:0][7:0] bytes;
    logic [2:0]                  count;
    logic [GROUP_BYTES-1:0]      cp_start;
    logic [GROUP_BYTES-1:0]      wide;
    logic                        fin;
  } usu_entry_t;

endpackage

FILE: src/usu_front.sv
// Front end: accepts text bytes, holds an unfinished sequence and splits
// the resolved bytes into code points. Depends on usu_pkg.
module usu_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              final_byte,
  input  logic              q_full,
  output logic              q_push,
  output usu_pkg::usu_entry_t q_entry
);

  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [7:0] MASK_2      = 8'hE0;
  localparam logic [7:0] LEAD_2      = 8'hC0;
  localparam logic [7:0] MASK_3      = 8'hF0;
  localparam logic [7:0] LEAD_3      = 8'hE0;
  localparam logic [7:0] MASK_4      = 8'hF8;
  localparam logic [7:0] LEAD_4      = 8'hF0;
  localparam logic [7:0] CONT_MASK   = 8'hC0;
  localparam logic [7:0] CONT_PAT    = 8'h80;

  logic [2:0][7:0] pend;
  logic [1:0]      pend_cnt;
  logic [2:0][7:0] pend_next;
  logic [1:0]      pend_cnt_next;

  logic [3:0][7:0] buf_b;
  logic [2:0]      n;
  logic [2:0]      pos;
  logic [3:0]      cps;
  logic [3:0]      wide;
  logic            accept;

  function automatic logic [1:0] cont_needed(input logic [7:0] b);
    logic [1:0] r;
    r = 2'd0;
    if (b < ASCII_LIMIT) r = 2'd0;
    else if ((b & MASK_2) == LEAD_2) r = 2'd1;
    else if ((b & MASK_3) == LEAD_3) r = 2'd2;
    else if ((b & MASK_4) == LEAD_4) r = 2'd3;
    return r;
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    logic       stop;
    logic [1:0] need;
    logic [2:0] avail;
    logic       ok;
    logic [2:0] idx;
    for (int i = 0; i < 4; i++) begin
      buf_b[i] = in_byte;
    end
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < pend_cnt) buf_b[i] = pend[i];
    end
    n     = {1'b0, pend_cnt} + 3'd1;
    pos   = 3'd0;
    stop  = 1'b0;
    cps   = '0;
    wide  = '0;
    need  = 2'd0;
    avail = 3'd0;
    ok    = 1'b1;
    idx   = 3'd0;
    for (int k = 0; k < 4; k++) begin
      if (!stop && pos < n) begin
        need  = cont_needed(buf_b[pos[1:0]]);
        avail = n - pos - 3'd1;
        ok    = 1'b1;
        for (int j = 1; j < 4; j++) begin
          idx = pos + 3'(j);
          if (2'(j) <= need && 3'(j) <= avail &&
              (buf_b[idx[1:0]] & CONT_MASK) != CONT_PAT) ok = 1'b0;
        end
        if (need != 2'd0 && ok && avail >= {1'b0, need}) begin
          cps[pos[1:0]]  = 1'b1;
          wide[pos[1:0]] = (need == 2'd3);
          pos = pos + {1'b0, need} + 3'd1;
        end else if (need != 2'd0 && ok && !final_byte) begin
          stop = 1'b1;
        end else begin
          cps[pos[1:0]] = 1'b1;
          pos = pos + 3'd1;
        end
      end
    end
    for (int i = 0; i < 3; i++) begin
      idx = pos + 3'(i);
      pend_next[i] = buf_b[idx[1:0]];
    end
    idx = n - pos;
    pend_cnt_next = final_byte ? 2'd0 : idx[1:0];
  end

  assign q_push           = accept && (pos != 3'd0);
  assign q_entry.bytes    = buf_b;
  assign q_entry.count    = pos;
  assign q_entry.cp_start = cps;
  assign q_entry.wide     = wide;
  assign q_entry.fin      = final_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_cnt <= 2'd0;
    end else if (accept) begin
      pend_cnt <= pend_cnt_next;
      pend     <= pend_next;
    end
  end

endmodule

FILE: src/usu_queue.sv
// Short queue of code-point groups between front end and emitter.
// Depends on usu_pkg.
module usu_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  usu_pkg::usu_entry_t wr_entry,
  output logic                full,
  input  logic                pop,
  output logic                rd_valid,
  output usu_pkg::usu_entry_t rd_entry
);

  localparam int PW = $clog2(usu_pkg::QUEUE_DEPTH);
  localparam int CNTW = $clog2(usu_pkg::QUEUE_DEPTH + 1);

  usu_pkg::usu_entry_t slots [usu_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   head;
  logic [PW-1:0]   tail;
  logic [CNTW-1:0] fill;

  assign full     = (fill == CNTW'(usu_pkg::QUEUE_DEPTH));
  assign rd_valid = (fill != '0);
  assign rd_entry = slots[head];

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        slots[tail] <= wr_entry;
        tail <= (tail == PW'(usu_pkg::QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (pop) begin
        head <= (head == PW'(usu_pkg::QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
      end
      if (push && !pop) fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

endmodule

FILE: src/usu_back.sv
// Emitter: walks each queued group one byte a cycle unless the result stalls,
// keeps the UTF-16 unit count, drives the registered result. Depends on usu_pkg.
module usu_back #(
  parameter int UNIT_COUNT_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [31:0]         start_pos,
  input  logic [31:0]         end_pos,
  input  logic                q_valid,
  input  usu_pkg::usu_entry_t q_entry,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                byte_valid,
  output logic                text_end,
  output logic                run_last
);

  localparam int UW = UNIT_COUNT_WIDTH;
  localparam int CW = (UW > 32) ? UW : 32;

  logic [UW-1:0] units;
  logic [1:0]    idx;
  logic          cur_in;
  logic          cur_next_in;
  logic          emitted;

  logic          step;
  logic          last_item;
  logic          cp_end;
  logic          is_start;
  logic [UW:0]   sum;
  logic [UW-1:0] units_inc;
  logic          in_now;
  logic          next_in;
  logic          emit;
  logic          last_now;
  logic          marker;
  logic [2:0]    last_idx;
  logic [1:0]    idx_up;

  assign step      = q_valid && (!out_valid || out_ready);
  assign last_idx  = q_entry.count - 3'd1;
  assign last_item = ({1'b0, idx} == last_idx);
  assign idx_up    = idx + 2'd1;
  assign cp_end    = last_item || q_entry.cp_start[idx_up];
  assign is_start  = q_entry.cp_start[idx];
  assign sum       = {1'b0, units} + (q_entry.wide[idx] ? (UW+1)'(2) : (UW+1)'(1));
  assign units_inc = sum[UW] ? '1 : sum[UW-1:0];

  assign in_now  = is_start ? (CW'(units) >= CW'(start_pos) && CW'(units) < CW'(end_pos))
                            : cur_in;
  assign next_in = is_start ? (CW'(units_inc) < CW'(end_pos)) : cur_next_in;
  assign emit     = in_now;
  assign last_now = emit && cp_end && (last_item || !next_in);
  assign marker   = last_item && q_entry.fin && !emitted && !emit;
  assign q_pop    = step && last_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      units       <= '0;
      idx         <= 2'd0;
      cur_in      <= 1'b0;
      cur_next_in <= 1'b0;
      emitted     <= 1'b0;
    end else begin
      if (step && (emit || marker)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (step) begin
        if (emit || marker) begin
          out_byte   <= emit ? q_entry.bytes[idx] : 8'h00;
          byte_valid <= emit;
          run_last   <= last_now || marker;
          text_end   <= (last_now || marker) && q_entry.fin;
        end
        if (last_item && q_entry.fin) units <= '0;
        else if (is_start) units <= units_inc;
        if (is_start) begin
          cur_in      <= in_now;
          cur_next_in <= next_in;
        end
        if (last_item) begin
          idx     <= 2'd0;
          emitted <= 1'b0;
        end else begin
          idx     <= idx_up;
          emitted <= emitted || emit;
        end
      end
    end
  end

endmodule

FILE: src/utf8_substring_by_utf16_units_top.sv
// Top level of the UTF-8 substring selector: configuration registers,
// front end, group queue and emitter. Depends on usu_pkg, usu_front,
// usu_queue and usu_back.
//
//   beat     | handshake             | payload
//   ---------+-----------------------+------------------------------------
//   input    | in_valid / in_ready   | in_byte, final_byte
//   result   | out_valid / out_ready | out_byte, byte_valid, text_end, run_last
//   config   | cfg_we                | cfg_index, cfg_data
//
// One input beat a cycle while the queue has room; the emitter walks a group
// of resolved bytes one byte a cycle while the output is not stalled, so the
// output runs at most one byte a cycle, set by the emitter's unit compare-and-add.
// With an empty queue a result is registered in a queue slot, then in the
// emitter's result register, behind any bytes ahead of it in the group.
// Synchronous reset clears the unit count, pending bytes, queue and result.
// Output stalls hold the emitter; the queue then fills and drops in_ready.
module utf8_substring_by_utf16_units_top #(
  parameter int UNIT_COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        final_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        text_end,
  output logic        run_last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam logic [1:0] CFG_START  = 2'd0;
  localparam logic [1:0] CFG_LENGTH = 2'd1;

  logic [31:0] start_pos;
  logic [31:0] length;
  logic [31:0] end_pos;
  logic [32:0] end_sum;

  logic                q_push;
  logic                q_full;
  logic                q_pop;
  logic                q_valid;
  usu_pkg::usu_entry_t wr_entry;
  usu_pkg::usu_entry_t rd_entry;

  always_comb begin
    end_sum = 33'd0;
    if (cfg_index == CFG_START) end_sum = {1'b0, cfg_data} + {1'b0, length};
    else if (cfg_index == CFG_LENGTH) end_sum = {1'b0, start_pos} + {1'b0, cfg_data};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_pos <= 32'd0;
      length    <= 32'd0;
      end_pos   <= 32'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START: begin
          start_pos <= cfg_data;
          end_pos   <= end_sum[32] ? '1 : end_sum[31:0];
        end
        CFG_LENGTH: begin
          length  <= cfg_data;
          end_pos <= end_sum[32] ? '1 : end_sum[31:0];
        end
        default: begin
        end
      endcase
    end
  end

  usu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .final_byte (final_byte),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (wr_entry)
  );

  usu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_entry (wr_entry),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_entry (rd_entry)
  );

  usu_back #(
    .UNIT_COUNT_WIDTH (UNIT_COUNT_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .start_pos  (start_pos),
    .end_pos    (end_pos),
    .q_valid    (q_valid),
    .q_entry    (rd_entry),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .text_end   (text_end),
    .run_last   (run_last)
  );

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && text_end |-> run_last)
    else $error("text_end without run_last");

  a_marker_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> text_end && out_byte == 8'h00)
    else $error("bare marker malformed");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full))
    else $error("group queue overflow");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

FILE: tb/usu_substring_checker.sv
`timescale 1ns / 1ps
// Register index constants and the result checker for the UTF-8 substring selector.
// The checker watches the input, result and register ports of
// utf8_substring_by_utf16_units_top, predicts every result beat and counts mismatches.
package usu_tb_pkg;
  localparam logic [1:0] REG_SUBSTRING_START  = 2'd0;
  localparam logic [1:0] REG_SUBSTRING_LENGTH = 2'd1;
  localparam logic [1:0] REG_SPARE_A          = 2'd2;
  localparam logic [1:0] REG_SPARE_B          = 2'd3;
endpackage

module usu_substring_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        final_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_byte,
  input  logic        byte_valid,
  input  logic        text_end,
  input  logic        run_last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          mismatch_count,
  output int          results_owed
);

  localparam logic [7:0]  CONT_MASK  = 8'hC0;
  localparam logic [7:0]  CONT_TAG   = 8'h80;
  localparam logic [7:0]  LEAD2_MASK = 8'hE0;
  localparam logic [7:0]  LEAD2_TAG  = 8'hC0;
  localparam logic [7:0]  LEAD3_MASK = 8'hF0;
  localparam logic [7:0]  LEAD3_TAG  = 8'hE0;
  localparam logic [7:0]  LEAD4_MASK = 8'hF8;
  localparam logic [7:0]  LEAD4_TAG  = 8'hF0;
  localparam logic [31:0] UNIT_MAX   = 32'hFFFF_FFFF;
  localparam int          MAX_REPORTS = 10;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       text_end;
    logic       run_last;
  } sub_beat_t;

  logic [31:0] sel_start;
  logic [31:0] sel_length;
  logic [31:0] units_seen;
  logic [7:0]  held_bytes [3];
  int          held_count;
  sub_beat_t   owed_q [$];
  sub_beat_t   seen;
  int          errors;

  function automatic int cont_bytes_needed(input logic [7:0] lead);
    if (!lead[7]) return 0;
    if ((lead & LEAD2_MASK) == LEAD2_TAG) return 1;
    if ((lead & LEAD3_MASK) == LEAD3_TAG) return 2;
    if ((lead & LEAD4_MASK) == LEAD4_TAG) return 3;
    return 0;
  endfunction

  // Group held bytes plus the new one into code points and queue the selected bytes.
  task automatic resolve_code_points(input logic [7:0] b, input logic fin);
    logic [7:0]  grp [4];
    sub_beat_t   made [4];
    logic [32:0] end_wide;
    logic [31:0] sel_end;
    logic [31:0] w;
    int          made_n;
    int          n;
    int          need;
    int          take;
    int          avail;
    int          chk;
    logic        ok;
    logic        stalled;
    end_wide = {1'b0, sel_start} + {1'b0, sel_length};
    sel_end = end_wide[32] ? UNIT_MAX : end_wide[31:0];
    for (int i = 0; i < held_count; i++) grp[i] = held_bytes[i];
    grp[held_count] = b;
    n = held_count + 1;
    made_n = 0;
    stalled = 1'b0;
    while (n > 0 && !stalled) begin
      need = cont_bytes_needed(grp[0]);
      take = 1;
      w = 32'd1;
      if (need > 0) begin
        avail = n - 1;
        chk = (avail < need) ? avail : need;
        ok = 1'b1;
        for (int k = 1; k <= chk; k++) begin
          if ((grp[k] & CONT_MASK) != CONT_TAG) ok = 1'b0;
        end
        if (ok && avail >= need) begin
          take = need + 1;
          w = (need == 3) ? 32'd2 : 32'd1;
        end else if (ok && !fin) begin
          stalled = 1'b1;
        end
      end
      if (!stalled) begin
        if (units_seen >= sel_start && units_seen < sel_end) begin
          for (int i = 0; i < take && made_n < 4; i++) begin
            made[made_n] = {grp[i], 1'b1, 1'b0, 1'b0};
            made_n++;
          end
        end
        if (UNIT_MAX - units_seen < w) units_seen = UNIT_MAX;
        else units_seen = units_seen + w;
        for (int i = 0; i + take < n; i++) grp[i] = grp[i + take];
        n = n - take;
      end
    end
    if (fin) begin
      if (made_n == 0) begin
        made[0] = {8'h00, 1'b0, 1'b0, 1'b0};
        made_n = 1;
      end
      made[made_n - 1].text_end = 1'b1;
      held_count = 0;
      units_seen = '0;
    end else begin
      for (int i = 0; i < n; i++) held_bytes[i] = grp[i];
      held_count = n;
    end
    if (made_n > 0) made[made_n - 1].run_last = 1'b1;
    for (int i = 0; i < made_n; i++) owed_q = {owed_q, made[i]};
  endtask

  task automatic note_mismatch(input string what, input sub_beat_t want, input sub_beat_t got);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("mismatch at %0t (%s): want %02h v%b e%b l%b, got %02h v%b e%b l%b",
               $time, what, want.out_byte, want.byte_valid, want.text_end, want.run_last,
               got.out_byte, got.byte_valid, got.text_end, got.run_last);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      sel_start = '0;
      sel_length = '0;
      units_seen = '0;
      held_count = 0;
      owed_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          usu_tb_pkg::REG_SUBSTRING_START:  sel_start = cfg_data;
          usu_tb_pkg::REG_SUBSTRING_LENGTH: sel_length = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) resolve_code_points(in_byte, final_byte);
      if (out_valid && out_ready) begin
        seen = {out_byte, byte_valid, text_end, run_last};
        if (owed_q.size() == 0) begin
          note_mismatch("no result owed", '0, seen);
        end else begin
          if (seen !== owed_q[0]) note_mismatch("wrong field", owed_q[0], seen);
          owed_q.pop_front();
        end
      end
    end
    mismatch_count <= errors;
    results_owed <= owed_q.size();
  end

endmodule

FILE: tb/utf8_substring_by_utf16_units_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for utf8_substring_by_utf16_units_top: sends directed and random
// UTF-8 texts under several substring windows with random stalls, and gives the
// verdict. Depends on usu_tb_pkg and usu_substring_checker.
module utf8_substring_by_utf16_units_top_tb;

  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_BEATS  = 96;
  localparam int PHASES        = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic [7:0]  in_byte = 8'h00;
  logic        final_byte = 1'b0;
  logic        out_ready = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = usu_tb_pkg::REG_SUBSTRING_START;
  logic [31:0] cfg_data = '0;
  logic        in_ready;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        text_end;
  logic        run_last;
  int          mismatch_count;
  int          results_owed;
  logic        quiet = 1'b0;
  int          beats_sent = 0;
  int          stall_left = 0;
  logic [7:0]  text_q [$];

  utf8_substring_by_utf16_units_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte), .final_byte(final_byte),
    .out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
    .byte_valid(byte_valid), .text_end(text_end), .run_last(run_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  usu_substring_checker watch (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte), .final_byte(final_byte),
    .out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
    .byte_valid(byte_valid), .text_end(text_end), .run_last(run_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatch_count(mismatch_count), .results_owed(results_owed)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (stall_left > 0) stall_left--;
    else if (!quiet && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 3);
    out_ready <= (stall_left == 0);
  end

  task automatic send_beat(input logic [7:0] b, input logic fin);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    final_byte <= fin;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_beat(text_q[i], i == text_q.size() - 1);
  endtask

  // Hold the sender until every owed result is back, then let the pipe settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_window(input logic [31:0] s, input logic [31:0] l);
    cfg_we <= 1'b1;
    cfg_index <= usu_tb_pkg::REG_SUBSTRING_START;
    cfg_data <= s;
    @(posedge clk);
    cfg_index <= usu_tb_pkg::REG_SUBSTRING_LENGTH;
    cfg_data <= l;
    @(posedge clk);
    cfg_index <= $urandom_range(0, 1) ? usu_tb_pkg::REG_SPARE_A : usu_tb_pkg::REG_SPARE_B;
    cfg_data <= $urandom;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly well-formed code points with random payload bits; some noise and broken ones.
  task automatic add_code_point();
    logic [7:0] rnd;
    logic [7:0] lead;
    int         kind;
    int         need;
    rnd = $urandom;
    kind = $urandom_range(0, 10);
    need = 0;
    case (kind)
      0, 1, 2: lead = {1'b0, rnd[6:0]};
      3, 4: begin
        lead = {3'b110, rnd[4:0]};
        need = 1;
      end
      5: begin
        lead = {4'b1110, rnd[3:0]};
        need = 2;
      end
      6: begin
        lead = {5'b11110, rnd[2:0]};
        need = 3;
      end
      7: lead = rnd;
      8: begin
        lead = {4'b1110, rnd[3:0]};
        need = $urandom_range(0, 1);
      end
      9: begin
        lead = {5'b11110, rnd[2:0]};
        need = $urandom_range(0, 2);
      end
      default: lead = {2'b10, rnd[5:0]};
    endcase
    text_q = {text_q, lead};
    repeat (need) text_q = {text_q, {2'b10, 6'($urandom)}};
  endtask

  task automatic random_text();
    int cps;
    cps = $urandom_range(1, 6);
    text_q.delete();
    repeat (cps) add_code_point();
    send_text();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    program_window(32'd0, 32'hFFFF_FFFF);
    text_q = '{8'h00, 8'h7F, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC,
               8'hF0, 8'h9F, 8'h98, 8'h80, 8'hFF, 8'h80};
    send_text();
    // wrong continuation, then a sequence cut off by the end of the text
    text_q = '{8'hE2, 8'h41};
    send_text();
    text_q = '{8'hF0, 8'h9F};
    send_text();

    // a four-byte sequence spans two units of the window
    wait_idle();
    program_window(32'd1, 32'd2);
    text_q = '{8'h41, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'h42};
    send_text();

    // empty window leaves a bare end marker
    wait_idle();
    program_window(32'd0, 32'd0);
    text_q = '{8'h41};
    send_text();

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p)
        0: program_window(32'd0, 32'hFFFF_FFFF);
        1: program_window(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        2: program_window(32'd2, 32'hFFFF_FFFF);
        3, 4: program_window($urandom_range(0, 4), $urandom_range(1, 6));
        5: program_window($urandom_range(0, 3), 32'd0);
        6: program_window($urandom_range(0, 8), $urandom_range(1, 10));
        default: begin
          quiet = 1'b1;
          program_window(32'd0, $urandom_range(1, 40));
        end
      endcase
      while (beats_sent < 24 + (p + 1) * RANDOM_BEATS / PHASES) random_text();
    end

    wait_idle();
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
